// File: rtl/calendar_date_arithmetic_top_assert.svh
// assertion macros for the calendar date unit
// each expects clk_i and rst_ni in scope
`ifndef CALENDAR_DATE_ARITHMETIC_TOP_ASSERT_SVH
`define CALENDAR_DATE_ARITHMETIC_TOP_ASSERT_SVH

// same-cycle implication
`define CDA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar date unit: same-cycle check failed");

// next-cycle implication
`define CDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar date unit: next-cycle check failed");

`endif

// File: rtl/cda_pkg.sv
`default_nettype none

package cda_pkg;

  localparam int MAX_YEAR   = 9999;
  localparam int MONTHS     = 12;
  localparam int DAYS_400Y  = 146097;
  localparam int DAYS_100Y  = 36524;
  localparam int DAYS_4Y    = 1461;
  localparam int DAYS_1Y    = 365;
  localparam int QUADS_CENT = 24;
  localparam int DIFF_MAX   = 4194303;
  localparam int DIFF_MIN   = -4194304;

  // serial number of MAX_YEAR-12-31, with 0001-01-01 as serial 0
  localparam int MAXP       = MAX_YEAR - 1;
  localparam int LEAP_MAX   = (((MAX_YEAR % 4 == 0) && (MAX_YEAR % 100 != 0)) ||
                               (MAX_YEAR % 400 == 0)) ? 1 : 0;
  localparam int SERIAL_MAX = 365 * MAXP + MAXP / 4 - MAXP / 100 + MAXP / 400 + 364 + LEAP_MAX;

  // accumulator holds a serial number plus a full 23-bit offset, signed
  localparam int ACC_W  = $clog2(SERIAL_MAX + 4194305) + 1;
  localparam int YEAR_W = ($clog2(MAX_YEAR + 1) > 14) ? $clog2(MAX_YEAR + 1) : 14;

  localparam logic signed [ACC_W-1:0] SERIAL_HI = ACC_W'(SERIAL_MAX);
  localparam logic signed [ACC_W-1:0] DIFF_HI   = ACC_W'(DIFF_MAX);
  localparam logic signed [ACC_W-1:0] DIFF_LO   = ACC_W'(DIFF_MIN);

  localparam logic [3:0] MONTH_FEB = 4'd2;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the year before the first of month m
  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    unique case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + 9'((leap && (m > MONTH_FEB)) ? 1 : 0);
  endfunction

endpackage

`default_nettype wire

// File: rtl/calendar_date_arithmetic_top.sv
`default_nettype none

// Gregorian date unit. op 0 shifts date A by a signed day offset, op 1 returns the
// signed day count A minus B with before and equal flags; an invalid date or a shifted
// date outside 0001-01-01 to 9999-12-31 gives error with all other fields zero.
// One request is taken at a time: in_ready_o is high only while the unit is idle, and a
// finished result sits in an output register so the next request can enter while it
// waits. Every step runs through one shared add/subtract unit: converting a date to a
// day number walks 400-year, century, 4-year and year spans and then adds the month
// and day, and converting back walks the same spans plus months.
module calendar_date_arithmetic_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               op_i,
  input  wire logic [13:0]        year_a_i,
  input  wire logic [3:0]         month_a_i,
  input  wire logic [4:0]         day_a_i,
  input  wire logic signed [22:0] offset_days_i,
  input  wire logic [13:0]        year_b_i,
  input  wire logic [3:0]         month_b_i,
  input  wire logic [4:0]         day_b_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [13:0]             res_year_o,
  output logic [3:0]              res_month_o,
  output logic [4:0]              res_day_o,
  output logic signed [22:0]      diff_days_o,
  output logic                    a_before_b_o,
  output logic                    dates_equal_o,
  output logic                    error_o
);

  localparam int AW = cda_pkg::ACC_W;
  localparam int YW = cda_pkg::YEAR_W;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_CHK  = 15'b000000000000010,
    S_Y400 = 15'b000000000000100,
    S_Y100 = 15'b000000000001000,
    S_Y4   = 15'b000000000010000,
    S_Y1   = 15'b000000000100000,
    S_MON  = 15'b000000001000000,
    S_NEXT = 15'b000000010000000,
    S_RNG  = 15'b000000100000000,
    S_D400 = 15'b000001000000000,
    S_D100 = 15'b000010000000000,
    S_D4   = 15'b000100000000000,
    S_D1   = 15'b001000000000000,
    S_DM   = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // captured request
  logic               op_q;
  logic [13:0]        ya_q, yb_q;
  logic [3:0]         ma_q, mb_q;
  logic [4:0]         da_q, db_q;
  logic signed [22:0] off_q;

  // working registers
  logic signed [AW-1:0] acc_q, acc_d;
  logic [YW-1:0]        rem_q, rem_d;
  logic [4:0]           cnt_q, cnt_d;
  logic [3:0]           m_q, m_d;
  logic                 sel_b_q, sel_b_d;
  logic                 c400_q, c400_d;
  logic                 c100_q, c100_d;
  logic                 err_q, err_d;

  // result register
  logic [13:0]        res_year_q;
  logic [3:0]         res_month_q;
  logic [4:0]         res_day_q;
  logic signed [22:0] diff_q;
  logic               before_q, equal_q, error_q;

  logic                 in_take;
  logic                 load;
  logic                 sub;
  logic signed [AW-1:0] mag;
  logic signed [AW-1:0] sum;
  logic                 sum_neg;
  logic [13:0]          cur_y;
  logic [3:0]           cur_m;
  logic [4:0]           cur_d;
  logic                 leap;
  logic [4:0]           mlen;
  logic                 shift_ok, diff_ok;
  logic signed [22:0]   diff_sat;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_take    = in_valid_i && in_ready_o;

  assign cur_y = sel_b_q ? yb_q : ya_q;
  assign cur_m = sel_b_q ? mb_q : ma_q;
  assign cur_d = sel_b_q ? db_q : da_q;

  // leap year from the span walk: forward pass sees (y-1) mod 400 and mod 100,
  // backward pass sees the century, 4-year and year counts
  always_comb begin
    if (state_q == S_DM) begin
      leap = (cnt_q == 5'd3) && (!c100_q || c400_q);
    end else begin
      leap = ((cur_y[1:0] == 2'b00) && !c100_q) || c400_q;
    end
  end

  assign mlen = cda_pkg::month_len((state_q == S_DM) ? m_q : cur_m, leap);

  // the shared add/subtract unit
  assign sum     = sub ? (acc_q - mag) : (acc_q + mag);
  assign sum_neg = sum[AW-1];

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    m_d     = m_q;
    sel_b_d = sel_b_q;
    c400_d  = c400_q;
    c100_d  = c100_q;
    err_d   = err_q;
    sub     = 1'b0;
    mag     = '0;
    load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          acc_d   = '0;
          sel_b_d = 1'b0;
          err_d   = 1'b0;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (cur_y == 14'd0 || YW'(cur_y) > YW'(cda_pkg::MAX_YEAR) ||
            cur_m == 4'd0 || cur_m > 4'(cda_pkg::MONTHS)) begin
          err_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          rem_d   = YW'(cur_y) - YW'(1);
          state_d = S_Y400;
        end
      end
      // date B is walked with the unit subtracting, so acc ends as A minus B
      S_Y400: begin
        mag = AW'(cda_pkg::DAYS_400Y);
        sub = sel_b_q;
        if (rem_q >= YW'(400)) begin
          acc_d = sum;
          rem_d = rem_q - YW'(400);
        end else begin
          c400_d  = (rem_q == YW'(399));
          state_d = S_Y100;
        end
      end
      S_Y100: begin
        mag = AW'(cda_pkg::DAYS_100Y);
        sub = sel_b_q;
        if (rem_q >= YW'(100)) begin
          acc_d = sum;
          rem_d = rem_q - YW'(100);
        end else begin
          c100_d  = (rem_q == YW'(99));
          state_d = S_Y4;
        end
      end
      S_Y4: begin
        mag = AW'(cda_pkg::DAYS_4Y);
        sub = sel_b_q;
        if (rem_q >= YW'(4)) begin
          acc_d = sum;
          rem_d = rem_q - YW'(4);
        end else begin
          state_d = S_Y1;
        end
      end
      S_Y1: begin
        mag = AW'(cda_pkg::DAYS_1Y);
        sub = sel_b_q;
        if (rem_q != '0) begin
          acc_d = sum;
          rem_d = rem_q - YW'(1);
        end else begin
          state_d = S_MON;
        end
      end
      S_MON: begin
        mag = AW'(cda_pkg::days_before(cur_m, leap)) + AW'(cur_d) - AW'(1);
        sub = sel_b_q;
        if (cur_d == 5'd0 || cur_d > mlen) begin
          err_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          acc_d   = sum;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (op_q) begin
          if (!sel_b_q) begin
            sel_b_d = 1'b1;
            state_d = S_CHK;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          mag     = AW'(off_q);
          acc_d   = sum;
          state_d = S_RNG;
        end
      end
      S_RNG: begin
        if (acc_q < 0 || acc_q > cda_pkg::SERIAL_HI) begin
          err_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          rem_d   = YW'(1);
          m_d     = 4'd1;
          cnt_d   = '0;
          state_d = S_D400;
        end
      end
      // backward walk: trial subtract, keep it when the result stays non-negative
      S_D400: begin
        mag = AW'(cda_pkg::DAYS_400Y);
        sub = 1'b1;
        if (!sum_neg) begin
          acc_d = sum;
          rem_d = rem_q + YW'(400);
        end else begin
          state_d = S_D100;
        end
      end
      S_D100: begin
        mag = AW'(cda_pkg::DAYS_100Y);
        sub = 1'b1;
        if (!sum_neg && cnt_q < 5'd3) begin
          acc_d = sum;
          rem_d = rem_q + YW'(100);
          cnt_d = cnt_q + 5'd1;
        end else begin
          c400_d  = (cnt_q == 5'd3);
          cnt_d   = '0;
          state_d = S_D4;
        end
      end
      S_D4: begin
        mag = AW'(cda_pkg::DAYS_4Y);
        sub = 1'b1;
        if (!sum_neg) begin
          acc_d = sum;
          rem_d = rem_q + YW'(4);
          cnt_d = cnt_q + 5'd1;
        end else begin
          c100_d  = (cnt_q == 5'(cda_pkg::QUADS_CENT));
          cnt_d   = '0;
          state_d = S_D1;
        end
      end
      S_D1: begin
        mag = AW'(cda_pkg::DAYS_1Y);
        sub = 1'b1;
        if (!sum_neg && cnt_q < 5'd3) begin
          acc_d = sum;
          rem_d = rem_q + YW'(1);
          cnt_d = cnt_q + 5'd1;
        end else begin
          state_d = S_DM;
        end
      end
      S_DM: begin
        mag = AW'(mlen);
        sub = 1'b1;
        if (!sum_neg && m_q < 4'(cda_pkg::MONTHS)) begin
          acc_d = sum;
          m_d   = m_q + 4'd1;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign shift_ok = !err_q && !op_q;
  assign diff_ok  = !err_q && op_q;

  always_comb begin
    if (acc_q > cda_pkg::DIFF_HI) begin
      diff_sat = 23'(cda_pkg::DIFF_MAX);
    end else if (acc_q < cda_pkg::DIFF_LO) begin
      diff_sat = 23'(cda_pkg::DIFF_MIN);
    end else begin
      diff_sat = acc_q[22:0];
    end
  end

  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q  <= op_i;
      ya_q  <= year_a_i;
      ma_q  <= month_a_i;
      da_q  <= day_a_i;
      off_q <= offset_days_i;
      yb_q  <= year_b_i;
      mb_q  <= month_b_i;
      db_q  <= day_b_i;
    end
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    m_q     <= m_d;
    sel_b_q <= sel_b_d;
    c400_q  <= c400_d;
    c100_q  <= c100_d;
    err_q   <= err_d;
    if (load) begin
      res_year_q  <= shift_ok ? rem_q[13:0] : 14'd0;
      res_month_q <= shift_ok ? m_q : 4'd0;
      res_day_q   <= shift_ok ? (acc_q[4:0] + 5'd1) : 5'd0;
      diff_q      <= diff_ok ? diff_sat : 23'sd0;
      before_q    <= diff_ok && (acc_q < 0);
      equal_q     <= diff_ok && (acc_q == 0);
      error_q     <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign res_year_o    = res_year_q;
  assign res_month_o   = res_month_q;
  assign res_day_o     = res_day_q;
  assign diff_days_o   = diff_q;
  assign a_before_b_o  = before_q;
  assign dates_equal_o = equal_q;
  assign error_o       = error_q;

endmodule

`default_nettype wire

// File: rtl/cda_checker.sv
`default_nettype none

`include "calendar_date_arithmetic_top_assert.svh"

module cda_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [13:0]        res_year_o,
  input wire logic [3:0]         res_month_o,
  input wire logic [4:0]         res_day_o,
  input wire logic signed [22:0] diff_days_o,
  input wire logic               a_before_b_o,
  input wire logic               dates_equal_o,
  input wire logic               error_o
);

  // a taken request leaves the unit busy in the cycle after it
  `CDA_ASSERT_NEXT(busy_after_take, in_valid_i && in_ready_o, !in_ready_o)

  // an error result carries nothing else
  `CDA_ASSERT_IMPL(error_clears_fields, out_valid_o && error_o,
                   res_year_o == 14'd0 && res_month_o == 4'd0 && res_day_o == 5'd0 &&
                   diff_days_o == 23'sd0 && !a_before_b_o && !dates_equal_o)

  // earlier and equal cannot both hold
  `CDA_ASSERT_IMPL(before_equal_excl, out_valid_o, !(a_before_b_o && dates_equal_o))

  // a stalled result holds
  `CDA_ASSERT_NEXT(result_holds, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(res_year_o) && $stable(res_day_o) &&
                   $stable(diff_days_o) && $stable(error_o))

endmodule

bind calendar_date_arithmetic_top cda_checker u_cda_checker (.*);

`default_nettype wire
